@@ rtl/scd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, codes and helpers of the packed counter record decoder.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int unsigned MaxCountersDef = 64;
  localparam int unsigned CountW         = 7;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned IndexW         = 6;
  localparam int unsigned ValueW         = 64;
  localparam int unsigned CodeW          = 2;
  localparam int unsigned InDataW        = 16;
  localparam int unsigned OutDataW       = 72;

  localparam logic       ActBegin   = 1'b0;
  localparam logic       ActByte    = 1'b1;
  localparam logic       StsCounter = 1'b0;
  localparam logic       StsStray   = 1'b1;

  localparam logic [CodeW-1:0] CodeZero = 2'd0;
  localparam logic [CodeW-1:0] Code16   = 2'd1;
  localparam logic [CodeW-1:0] Code32   = 2'd2;
  localparam logic [CodeW-1:0] Code64   = 2'd3;
  localparam logic [CodeW-1:0] CodeMask = 2'h3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic begin_ld;
    logic desc_wr;
    logic data_start;
    logic data_wr;
    logic emit_zero;
    logic emit_value;
    logic emit_stray;
  } scd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             out_free;
    logic             total_zero;
    logic             desc_last;
    logic             data_last;
    logic             idx_end;
    logic [CodeW-1:0] cur_code;
  } scd_sts_t;

  // Position of the final data byte of a counter with the given size code.
  function automatic logic [2:0] last_byte_pos(input logic [CodeW-1:0] code);
    logic [2:0] pos;
    case (code)
      Code16:  pos = 3'd1;
      Code32:  pos = 3'd3;
      default: pos = 3'd7;
    endcase
    return pos;
  endfunction

endpackage

@@ rtl/stats_counter_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stats_counter_decoder
// Decodes packed counter records from a byte stream into one beat per counter.
// ----------------------------------------------------------------------------
// Input beats are taken at one per cycle while the output register is free.
// A counter completed by a data byte appears on the output in the cycle after that byte is taken.
// After the last descriptor byte or a completed counter, zero-coded counters
// leave at one per cycle while the output register is free, with the input
// held off until the zero run ends. Reset is asynchronous and active low; it
// clears the sequencer, counters and output valid, not the descriptor store.
module stats_counter_decoder import scd_pkg::*; #(
  parameter int unsigned MAX_COUNTERS = MaxCountersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // count[6:0], data_byte[14:7], zero pad
  input  logic                s_axis_tuser,  // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // counter_index[5:0], value[69:6], code[71:70]
  output logic                m_axis_tuser,  // status
  output logic                m_axis_tlast   // last
);

  scd_cmd_t          cmd;
  scd_sts_t          sts;
  logic [IndexW-1:0] out_index;
  logic [ValueW-1:0] out_value;
  logic [CodeW-1:0]  out_code;

  scd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scd_datapath #(
    .MAX_COUNTERS (MAX_COUNTERS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .count_i      (s_axis_tdata[CountW-1:0]),
    .byte_i       (s_axis_tdata[CountW +: ByteW]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_index_o  (out_index),
    .out_value_o  (out_value),
    .out_code_o   (out_code),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_code, out_value, out_index};

endmodule

@@ rtl/scd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_datapath
// Descriptor store, record counters, value assembly and output register.
// ----------------------------------------------------------------------------
module scd_datapath import scd_pkg::*; #(
  parameter int unsigned MAX_COUNTERS = MaxCountersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scd_cmd_t            cmd_i,
  output scd_sts_t            sts_o,
  input  logic [CountW-1:0]   count_i,
  input  logic [ByteW-1:0]    byte_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_status_o,
  output logic [IndexW-1:0]   out_index_o,
  output logic [ValueW-1:0]   out_value_o,
  output logic [CodeW-1:0]    out_code_o,
  output logic                out_last_o
);

  localparam int unsigned Cap  = (MAX_COUNTERS < 64) ? MAX_COUNTERS : 64;
  localparam int unsigned IW   = $clog2(Cap + 1);
  localparam int unsigned DB   = (Cap + 3) / 4;
  localparam int unsigned DPW  = (DB > 1) ? $clog2(DB) : 1;
  localparam int unsigned DLW  = $clog2(DB + 1);

  // One descriptor byte holds the codes of four consecutive counters.
  logic [ByteW-1:0] desc_q [DB];

  logic [IW-1:0]     total_q, total_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [DLW-1:0]    desc_left_q, desc_left_d;
  logic [DPW-1:0]    desc_ptr_q, desc_ptr_d;
  logic [2:0]        byte_cnt_q, byte_cnt_d;
  logic [ValueW-1:0] value_q, value_d, value_nx;
  logic [IW:0]       desc_bytes_new;
  logic [IW-1:0]     total_new;
  logic [ByteW-1:0]  cur_word;
  logic [CodeW-1:0]  cur_code;
  logic [IW-1:0]     idx_word;
  logic              idx_last;
  logic              out_valid_q;

  assign total_new      = (count_i > CountW'(Cap)) ? IW'(Cap) : IW'(count_i);
  assign desc_bytes_new = ({1'b0, total_new} + (IW + 1)'(3)) >> 2;
  assign idx_word       = idx_q >> 2;
  assign cur_word       = desc_q[idx_word[DPW-1:0]];
  assign cur_code       = CodeW'(cur_word >> {idx_q[1:0], 1'b0}) & CodeMask;
  assign idx_last       = (({1'b0, idx_q} + (IW + 1)'(1)) == {1'b0, total_q});

  always_comb begin
    value_nx = value_q;
    value_nx[byte_cnt_q*ByteW +: ByteW] = byte_i;
  end

  always_comb begin
    total_d     = total_q;
    idx_d       = idx_q;
    desc_left_d = desc_left_q;
    desc_ptr_d  = desc_ptr_q;
    byte_cnt_d  = byte_cnt_q;
    value_d     = value_q;
    if (cmd_i.begin_ld) begin
      total_d     = total_new;
      idx_d       = '0;
      desc_left_d = DLW'(desc_bytes_new);
      desc_ptr_d  = '0;
    end
    if (cmd_i.desc_wr) begin
      desc_left_d = desc_left_q - DLW'(1);
      desc_ptr_d  = desc_ptr_q + DPW'(1);
    end
    if (cmd_i.data_start) begin
      byte_cnt_d = '0;
      value_d    = '0;
    end
    if (cmd_i.data_wr) begin
      byte_cnt_d = byte_cnt_q + 3'd1;
      value_d    = value_nx;
    end
    if (cmd_i.emit_zero || cmd_i.emit_value) begin
      idx_d = idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      idx_q       <= '0;
      desc_left_q <= '0;
      desc_ptr_q  <= '0;
      byte_cnt_q  <= '0;
    end else begin
      total_q     <= total_d;
      idx_q       <= idx_d;
      desc_left_q <= desc_left_d;
      desc_ptr_q  <= desc_ptr_d;
      byte_cnt_q  <= byte_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (cmd_i.desc_wr) begin
      desc_q[desc_ptr_q] <= byte_i;
    end
  end

  // Output register: one result beat, held until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_zero || cmd_i.emit_value || cmd_i.emit_stray) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_stray) begin
      out_status_o <= StsStray;
      out_index_o  <= '0;
      out_value_o  <= '0;
      out_code_o   <= CodeZero;
      out_last_o   <= 1'b0;
    end else if (cmd_i.emit_zero || cmd_i.emit_value) begin
      out_status_o <= StsCounter;
      out_index_o  <= IndexW'(idx_q);
      out_value_o  <= cmd_i.emit_value ? value_nx : '0;
      out_code_o   <= cur_code;
      out_last_o   <= idx_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.total_zero = (total_new == '0);
  assign sts_o.desc_last  = (desc_left_q == DLW'(1));
  assign sts_o.data_last  = (byte_cnt_q == last_byte_pos(cur_code));
  assign sts_o.idx_end    = (idx_q >= total_q);
  assign sts_o.cur_code   = cur_code;

endmodule

@@ rtl/scd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_ctrl
// Record sequencer: descriptor phase, data phase and zero-counter runs.
// ----------------------------------------------------------------------------
module scd_ctrl import scd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_action_i,
  output logic     in_ready_o,
  input  scd_sts_t sts_i,
  output scd_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDesc,
    StData,
    StZrun
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign in_ready_o = (state_q != StZrun) && sts_i.out_free;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (state_q == StZrun) begin
      // Walk the record from the current index: zero counters go out one per
      // cycle while the output is free, a nonzero one opens the data phase.
      if (sts_i.idx_end) begin
        state_d = StIdle;
      end else if (sts_i.cur_code == CodeZero) begin
        cmd_o.emit_zero = sts_i.out_free;
      end else begin
        cmd_o.data_start = 1'b1;
        state_d          = StData;
      end
    end else if (acc) begin
      if (in_action_i == ActBegin) begin
        cmd_o.begin_ld = 1'b1;
        state_d        = sts_i.total_zero ? StIdle : StDesc;
      end else begin
        unique case (state_q)
          StDesc: begin
            cmd_o.desc_wr = 1'b1;
            if (sts_i.desc_last) begin
              state_d = StZrun;
            end
          end
          StData: begin
            cmd_o.data_wr = 1'b1;
            if (sts_i.data_last) begin
              cmd_o.emit_value = 1'b1;
              state_d          = StZrun;
            end
          end
          default: begin
            cmd_o.emit_stray = 1'b1;
            state_d          = StIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sim/tb_stats_counter_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stats_counter_decoder
// Self-checking testbench of the packed counter record decoder. Input beats
// run through a predictor that tracks the record phase, the descriptor codes
// and the value assembly. Each output beat is compared field by field with
// the oldest predicted counter beat. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_stats_counter_decoder;
  import scd_pkg::*;

  localparam int unsigned CountCap    = (MaxCountersDef < 64) ? MaxCountersDef : 64;
  localparam int unsigned RandomBeats = 150;
  localparam int unsigned CalmBeats   = 30;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PrintCap    = 40;

  typedef enum logic [1:0] {PhIdle, PhDesc, PhData} rec_phase_e;

  typedef struct packed {
    logic              status;
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
    logic [CodeW-1:0]  code;
    logic              last;
  } counter_beat_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = ActBegin;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  // Predictor state.
  logic [CodeW-1:0]  rec_codes [CountCap];
  rec_phase_e        rec_phase   = PhIdle;
  logic [CountW-1:0] rec_total   = '0;
  int unsigned       desc_left   = 0;
  logic [CountW-1:0] rec_index   = '0;
  logic [ValueW-1:0] value_acc   = '0;
  int unsigned       bytes_left  = 0;

  counter_beat_t expected_beats[$];

  bit          calm          = 1'b0;
  int unsigned mismatches    = 0;
  int unsigned beats_sent    = 0;
  int unsigned counters_seen = 0;
  int unsigned strays_seen   = 0;
  int unsigned records_begun = 0;
  int unsigned cycle_cnt     = 0;

  stats_counter_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt,
               expected_beats.size());
      $display("[stats_counter_decoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned code_bytes(input logic [CodeW-1:0] code);
    case (code)
      Code16:  return 2;
      Code32:  return 4;
      default: return 8;
    endcase
  endfunction

  function automatic void push_expected(input logic sts, input logic [CountW-1:0] idx,
                                        input logic [ValueW-1:0] val,
                                        input logic [CodeW-1:0] code, input logic lst);
    counter_beat_t b;
    b.status = sts;
    b.index  = idx[IndexW-1:0];
    b.value  = val;
    b.code   = code;
    b.last   = lst;
    expected_beats.push_back(b);
  endfunction

  // Zero-coded counters leave without data; stop at the next nonzero one.
  function automatic void emit_zero_run();
    while (rec_index < rec_total && rec_codes[rec_index] == CodeZero) begin
      push_expected(StsCounter, rec_index, '0, CodeZero, rec_index + 7'd1 == rec_total);
      rec_index++;
    end
    if (rec_index >= rec_total) begin
      rec_phase  = PhIdle;
      bytes_left = 0;
    end else begin
      rec_phase  = PhData;
      bytes_left = code_bytes(rec_codes[rec_index]);
      value_acc  = '0;
    end
  endfunction

  function automatic void predict_beat(input logic act, input logic [CountW-1:0] cnt,
                                       input logic [ByteW-1:0] dbyte);
    int unsigned base;
    int unsigned pos;
    logic [CodeW-1:0] code;
    if (act == ActBegin) begin
      rec_total  = (cnt > CountCap) ? CountW'(CountCap) : cnt;
      rec_index  = '0;
      value_acc  = '0;
      bytes_left = 0;
      if (rec_total == 0) begin
        rec_phase = PhIdle;
        desc_left = 0;
      end else begin
        rec_phase = PhDesc;
        desc_left = (rec_total + 3) / 4;
      end
    end else if (rec_phase == PhDesc) begin
      base = ((rec_total + 3) / 4 - desc_left) * 4;
      for (int j = 0; j < 4; j++) begin
        // Codes beyond the record total are padding.
        if (base + j < rec_total) rec_codes[base + j] = dbyte[2*j +: 2];
      end
      desc_left--;
      if (desc_left == 0) emit_zero_run();
    end else if (rec_phase == PhData && rec_index < rec_total) begin
      code = rec_codes[rec_index];
      pos  = code_bytes(code) - bytes_left;
      value_acc[pos*8 +: 8] = dbyte;
      bytes_left--;
      if (bytes_left == 0) begin
        push_expected(StsCounter, rec_index, value_acc, code, rec_index + 7'd1 == rec_total);
        rec_index++;
        emit_zero_run();
      end
    end else begin
      rec_phase = PhIdle;
      push_expected(StsStray, '0, '0, CodeZero, 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintCap) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic check_result();
    counter_beat_t want;
    logic [IndexW-1:0] got_index;
    logic [ValueW-1:0] got_value;
    logic [CodeW-1:0]  got_code;
    got_index = m_axis_tdata[IndexW-1:0];
    got_value = m_axis_tdata[IndexW +: ValueW];
    got_code  = m_axis_tdata[IndexW+ValueW +: CodeW];
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat, index %0d value %h", got_index, got_value));
    end else begin
      want = expected_beats.pop_front();
      if (want.status == StsStray) strays_seen++;
      else counters_seen++;
      if (m_axis_tuser !== want.status)
        report_mismatch($sformatf("status %b, want %b", m_axis_tuser, want.status));
      if (got_index !== want.index)
        report_mismatch($sformatf("index %0d, want %0d", got_index, want.index));
      if (got_value !== want.value)
        report_mismatch($sformatf("index %0d value %h, want %h", want.index, got_value,
                                  want.value));
      if (got_code !== want.code)
        report_mismatch($sformatf("index %0d code %0d, want %0d", want.index, got_code,
                                  want.code));
      if (m_axis_tlast !== want.last)
        report_mismatch($sformatf("index %0d last %b, want %b", want.index, m_axis_tlast,
                                  want.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
  end

  // Output back-pressure in random bursts.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 12)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic act, input logic [CountW-1:0] cnt,
                           input logic [ByteW-1:0] dbyte);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, dbyte, cnt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_beat(act, cnt, dbyte);
    beats_sent++;
    if (act == ActBegin) records_begun++;
  endtask

  function automatic logic [ByteW-1:0] random_data_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  // Descriptor byte whose codes are zero with probability zero_weight/8.
  function automatic logic [ByteW-1:0] random_desc_byte(input int unsigned zero_weight);
    logic [ByteW-1:0] d;
    for (int j = 0; j < 4; j++) begin
      if ($urandom_range(0, 7) < zero_weight) d[2*j +: 2] = CodeZero;
      else d[2*j +: 2] = CodeW'($urandom_range(1, 3));
    end
    return d;
  endfunction

  function automatic logic [CountW-1:0] random_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return CountW'($urandom_range(1, 8));
    else if (r < 17) return CountW'($urandom_range(9, 63));
    else if (r == 17) return CountW'(64);
    else if (r == 18) return CountW'($urandom_range(65, 127));
    else return '0;
  endfunction

  // A cut-short record stops after a few beats and is left to the next begin.
  task automatic send_record(input logic [CountW-1:0] cnt, input bit cut_short);
    int unsigned budget;
    int unsigned zero_weight;
    zero_weight = (cnt > 16) ? 7 : 2;
    budget      = cut_short ? $urandom_range(1, 12) : 32'hFFFF_FFFF;
    send_beat(ActBegin, cnt, random_data_byte());
    while (rec_phase == PhDesc && budget > 0) begin
      send_beat(ActByte, CountW'($urandom_range(0, 127)), random_desc_byte(zero_weight));
      budget--;
    end
    while (rec_phase == PhData && budget > 0) begin
      send_beat(ActByte, CountW'($urandom_range(0, 127)), random_data_byte());
      budget--;
    end
  endtask

  task automatic test_stray_byte();
    send_beat(ActByte, 7'h7F, 8'hFF);
  endtask

  task automatic test_empty_record();
    send_beat(ActBegin, 7'd0, 8'h5A);
    send_beat(ActByte, 7'd0, 8'h00);
  endtask

  // Codes 16, 32 and 64 bits with the padding pair set, extreme values.
  task automatic test_code_widths();
    send_beat(ActBegin, 7'd3, 8'hAA);
    send_beat(ActByte, 7'd0, 8'hF9);
    send_beat(ActByte, 7'd0, 8'hFF);
    send_beat(ActByte, 7'd0, 8'hFF);
    send_beat(ActByte, 7'd0, 8'h01);
    send_beat(ActByte, 7'd0, 8'h00);
    send_beat(ActByte, 7'd0, 8'h00);
    send_beat(ActByte, 7'd0, 8'h80);
    repeat (8) send_beat(ActByte, 7'd0, 8'hFF);
  endtask

  // A begin in the middle of a counter abandons the record in progress.
  task automatic test_restart_busy();
    send_beat(ActBegin, 7'd4, 8'h00);
    send_beat(ActByte, 7'd0, 8'h55);
    send_beat(ActByte, 7'd0, 8'h11);
    send_beat(ActBegin, 7'd2, 8'h00);
    send_beat(ActByte, 7'd0, 8'h04);
    send_beat(ActByte, 7'd0, 8'h34);
    send_beat(ActByte, 7'd0, 8'h12);
  endtask

  task automatic test_random_records();
    int unsigned stop_at;
    int unsigned sel;
    stop_at = beats_sent + RandomBeats;
    // The oversized count saturates to the store depth; then a full record.
    send_record(CountW'($urandom_range(65, 127)), 1'b0);
    send_record(CountW'(64), 1'b0);
    while (beats_sent < stop_at) begin
      if (beats_sent + CalmBeats >= stop_at) calm = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel == 0 && rec_phase == PhIdle)
        send_beat(ActByte, CountW'($urandom_range(0, 127)), random_data_byte());
      else if (sel == 1)
        send_beat(ActBegin, '0, random_data_byte());
      else
        send_record(random_count(), sel == 2);
    end
    calm = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stray_byte();
    test_empty_record();
    test_code_widths();
    test_restart_busy();
    test_random_records();
    s_axis_tvalid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));

    $display("Sent %0d input beats over %0d records; checked %0d counters and %0d strays.",
             beats_sent, records_begun, counters_seen, strays_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[stats_counter_decoder] OK");
    end else begin
      $display("[stats_counter_decoder] ERROR");
    end
    $finish;
  end

endmodule
